>>> hw/rtl/cau_pkg.sv
// shared types, constants and helper functions for the complex arithmetic unit
// no dependencies; imported by every module of the unit
`default_nettype none

package cau_pkg;

	localparam int DATA_WIDTH     = 16;
	localparam int FRAC_BITS      = 8;
	localparam int PROD_WIDTH     = 2 * DATA_WIDTH;
	localparam int DVD_WIDTH      = PROD_WIDTH + FRAC_BITS;
	localparam int CMP_WIDTH      = 3 * DATA_WIDTH;
	localparam int ROOT_REM_WIDTH = DATA_WIDTH + 3;

	typedef enum logic [2:0] {
		MODE_ADD  = 3'd0,
		MODE_SUB  = 3'd1,
		MODE_MUL  = 3'd2,
		MODE_DIV  = 3'd3,
		MODE_MOD  = 3'd4,
		MODE_CONJ = 3'd5
	} mode_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	typedef struct packed {
		logic [2:0]                   mode;
		logic signed [DATA_WIDTH-1:0] a_real;
		logic signed [DATA_WIDTH-1:0] a_imag;
		logic signed [DATA_WIDTH-1:0] b_real;
		logic signed [DATA_WIDTH-1:0] b_imag;
	} in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] res_real;
		logic signed [DATA_WIDTH-1:0] res_imag;
		logic [1:0]                   status;
	} out_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] value;
		logic                         sat;
	} sat_t;

	// item state while the divider and root iterations run
	typedef struct packed {
		logic [2:0]                   mode;
		logic signed [DATA_WIDTH-1:0] res_r;
		logic signed [DATA_WIDTH-1:0] res_i;
		logic                         sat;
		logic                         divz;
		logic                         neg_r;
		logic                         neg_i;
		logic                         ovf_r;
		logic                         ovf_i;
		logic [PROD_WIDTH-1:0]        den;
		logic [PROD_WIDTH-1:0]        rem_r;
		logic [PROD_WIDTH-1:0]        rem_i;
		logic [DATA_WIDTH-1:0]        dlow_r;
		logic [DATA_WIDTH-1:0]        dlow_i;
		logic [DATA_WIDTH-1:0]        q_r;
		logic [DATA_WIDTH-1:0]        q_i;
		logic [PROD_WIDTH-1:0]        sq_n;
		logic [ROOT_REM_WIDTH-1:0]    sq_rem;
		logic [DATA_WIDTH-1:0]        sq_root;
	} work_t;

	localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] NEG_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// clip a wide signed value to the data width
	function automatic sat_t saturate(input logic signed [PROD_WIDTH:0] v);
		sat_t r;
		logic signed [PROD_WIDTH:0] hi;
		logic signed [PROD_WIDTH:0] lo;
		hi = {{(PROD_WIDTH-DATA_WIDTH+2){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
		lo = {{(PROD_WIDTH-DATA_WIDTH+2){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
		if (v > hi) begin
			r.value = POS_MAX;
			r.sat   = 1'b1;
		end else if (v < lo) begin
			r.value = NEG_MIN;
			r.sat   = 1'b1;
		end else begin
			r.value = v[DATA_WIDTH-1:0];
			r.sat   = 1'b0;
		end
		return r;
	endfunction

	// sign and clip a quotient magnitude
	function automatic sat_t div_fix(input logic neg, input logic ovf,
			input logic [DATA_WIDTH-1:0] q);
		sat_t r;
		if (ovf) begin
			r.value = neg ? NEG_MIN : POS_MAX;
			r.sat   = 1'b1;
		end else if (!neg) begin
			r.sat   = q > POS_MAX;
			r.value = r.sat ? POS_MAX : q;
		end else begin
			r.sat   = q > NEG_MIN;
			r.value = r.sat ? NEG_MIN : (~q + 1'b1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cau_front.sv
// front stages: products, exact sums, magnitudes and divider set-up
// depends on cau_pkg
`default_nettype none

module cau_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire cau_pkg::in_t  op,
	output logic               out_valid,
	output cau_pkg::work_t     work
);
	import cau_pkg::*;

	// stage 1: products and narrow sums
	logic                         valid_s1;
	logic [2:0]                   mode_s1;
	logic signed [PROD_WIDTH-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [PROD_WIDTH-1:0] sq1_s1, sq2_s1;
	logic signed [DATA_WIDTH:0]   sum_r_s1, sum_i_s1;

	logic signed [DATA_WIDTH-1:0] x1, x2;
	logic signed [DATA_WIDTH:0]   sr, si;

	always_comb begin
		x1 = (op.mode == MODE_MOD) ? op.a_real : op.b_real;
		x2 = (op.mode == MODE_MOD) ? op.a_imag : op.b_imag;
		sr = '0;
		si = '0;
		case (op.mode)
			MODE_ADD: begin
				sr = op.a_real + op.b_real;
				si = op.a_imag + op.b_imag;
			end
			MODE_SUB: begin
				sr = op.a_real - op.b_real;
				si = op.a_imag - op.b_imag;
			end
			MODE_CONJ: begin
				sr = op.a_real;
				si = -op.a_imag;
			end
			default: begin
				sr = '0;
				si = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1  <= op.mode;
			p_rr_s1  <= op.a_real * op.b_real;
			p_ii_s1  <= op.a_imag * op.b_imag;
			p_ri_s1  <= op.a_real * op.b_imag;
			p_ir_s1  <= op.a_imag * op.b_real;
			sq1_s1   <= x1 * x1;
			sq2_s1   <= x2 * x2;
			sum_r_s1 <= sr;
			sum_i_s1 <= si;
		end
	end

	// stage 2: exact component sums
	logic                       valid_s2;
	logic [2:0]                 mode_s2;
	logic signed [PROD_WIDTH:0] mulr_s2, muli_s2, dnr_s2, dni_s2;
	logic [PROD_WIDTH-1:0]      sqs_s2;
	logic signed [DATA_WIDTH:0] sum_r_s2, sum_i_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2  <= mode_s1;
			mulr_s2  <= p_rr_s1 - p_ii_s1;
			muli_s2  <= p_ri_s1 + p_ir_s1;
			dnr_s2   <= p_rr_s1 + p_ii_s1;
			dni_s2   <= p_ir_s1 - p_ri_s1;
			sqs_s2   <= PROD_WIDTH'($unsigned(sq1_s1) + $unsigned(sq2_s1));
			sum_r_s2 <= sum_r_s1;
			sum_i_s2 <= sum_i_s1;
		end
	end

	// stage 3: clipping of the direct results, divider set-up
	logic                       neg_r, neg_i;
	logic signed [PROD_WIDTH:0] abs_r, abs_i;
	logic [DVD_WIDTH-1:0]       dvd_r, dvd_i;
	logic [CMP_WIDTH-1:0]       den_sh;
	sat_t                       cr, ci;
	work_t                      nxt;

	always_comb begin
		neg_r  = dnr_s2[PROD_WIDTH];
		neg_i  = dni_s2[PROD_WIDTH];
		abs_r  = neg_r ? -dnr_s2 : dnr_s2;
		abs_i  = neg_i ? -dni_s2 : dni_s2;
		dvd_r  = DVD_WIDTH'(abs_r[PROD_WIDTH-1:0]) << FRAC_BITS;
		dvd_i  = DVD_WIDTH'(abs_i[PROD_WIDTH-1:0]) << FRAC_BITS;
		den_sh = CMP_WIDTH'(sqs_s2) << DATA_WIDTH;

		cr = '0;
		ci = '0;
		case (mode_s2)
			MODE_MUL: begin
				cr = saturate(mulr_s2 >>> FRAC_BITS);
				ci = saturate(muli_s2 >>> FRAC_BITS);
			end
			MODE_ADD, MODE_SUB, MODE_CONJ: begin
				cr = saturate({{(PROD_WIDTH-DATA_WIDTH){sum_r_s2[DATA_WIDTH]}}, sum_r_s2});
				ci = saturate({{(PROD_WIDTH-DATA_WIDTH){sum_i_s2[DATA_WIDTH]}}, sum_i_s2});
			end
			default: begin
				cr = '0;
				ci = '0;
			end
		endcase

		nxt         = '0;
		nxt.mode    = mode_s2;
		nxt.res_r   = cr.value;
		nxt.res_i   = ci.value;
		nxt.sat     = cr.sat | ci.sat;
		nxt.divz    = (sqs_s2 == '0);
		nxt.neg_r   = neg_r;
		nxt.neg_i   = neg_i;
		nxt.ovf_r   = CMP_WIDTH'(dvd_r) >= den_sh;
		nxt.ovf_i   = CMP_WIDTH'(dvd_i) >= den_sh;
		nxt.den     = sqs_s2;
		nxt.rem_r   = PROD_WIDTH'(dvd_r >> DATA_WIDTH);
		nxt.rem_i   = PROD_WIDTH'(dvd_i >> DATA_WIDTH);
		nxt.dlow_r  = dvd_r[DATA_WIDTH-1:0];
		nxt.dlow_i  = dvd_i[DATA_WIDTH-1:0];
		nxt.sq_n    = sqs_s2;
	end

	logic  valid_s3;
	work_t work_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s3 <= nxt;
		end
	end

	assign out_valid = valid_s3;
	assign work      = work_s3;

endmodule

`default_nettype wire

>>> hw/rtl/cau_iter.sv
// one pipeline stage of the two restoring dividers and the square root
// depends on cau_pkg; STEP picks the quotient bit and radicand bit pair
`default_nettype none

module cau_iter #(
	parameter int STEP = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire cau_pkg::work_t w_in,
	output logic                out_valid,
	output cau_pkg::work_t      w_out
);
	import cau_pkg::*;

	localparam int QBIT = DATA_WIDTH - 1 - STEP;
	localparam int NBIT = PROD_WIDTH - 2 - 2 * STEP;

	logic [PROD_WIDTH:0]       tr_r, tr_i, den_x;
	logic [ROOT_REM_WIDTH-1:0] t2, trial;
	work_t                     nxt;

	always_comb begin
		nxt   = w_in;
		den_x = {1'b0, w_in.den};

		tr_r = {w_in.rem_r, w_in.dlow_r[QBIT]};
		if (tr_r >= den_x) begin
			nxt.rem_r       = PROD_WIDTH'(tr_r - den_x);
			nxt.q_r[QBIT]   = 1'b1;
		end else begin
			nxt.rem_r       = tr_r[PROD_WIDTH-1:0];
		end

		tr_i = {w_in.rem_i, w_in.dlow_i[QBIT]};
		if (tr_i >= den_x) begin
			nxt.rem_i       = PROD_WIDTH'(tr_i - den_x);
			nxt.q_i[QBIT]   = 1'b1;
		end else begin
			nxt.rem_i       = tr_i[PROD_WIDTH-1:0];
		end

		// digit-by-digit root, two radicand bits a step
		t2    = {w_in.sq_rem[ROOT_REM_WIDTH-3:0], w_in.sq_n[NBIT+1:NBIT]};
		trial = ROOT_REM_WIDTH'({w_in.sq_root, 2'b01});
		if (t2 >= trial) begin
			nxt.sq_rem  = t2 - trial;
			nxt.sq_root = {w_in.sq_root[DATA_WIDTH-2:0], 1'b1};
		end else begin
			nxt.sq_rem  = t2;
			nxt.sq_root = {w_in.sq_root[DATA_WIDTH-2:0], 1'b0};
		end
	end

	logic  valid_s1;
	work_t work_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign w_out     = work_s1;

endmodule

`default_nettype wire

>>> hw/rtl/complex_arithmetic_unit.sv
// complex arithmetic unit top level: front stages, divider/root chain, output register
// depends on cau_pkg, cau_front and cau_iter
//
// usage
//   op channel (op_valid, op_stall, op) carries one item: mode and the two
//   operands a and b in signed Q8.8; res channel (res_valid, res_stall, res)
//   returns one item per op item, in order: res_real, res_imag, status
//   modes: add, subtract, multiply, divide a by b, modulus of a, conjugate of a
//   an item is taken on a clock edge with valid high and stall low
// timing
//   the pipeline has three front stages (products, sums, set-up), one stage per
//   quotient bit of the dividers and square root, and the output register
//   one item per cycle unless stalled; every item walks the full divider chain
// reset
//   arst_n clears all valid bits at once; no item is in flight afterwards
// stall
//   a stalled result holds in the output register; the whole pipeline freezes
//   and op_stall rises in the same cycle, so nothing is lost or repeated
`default_nettype none

module complex_arithmetic_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_valid,
	output logic               op_stall,
	input  wire cau_pkg::in_t  op,
	output logic               res_valid,
	input  wire logic          res_stall,
	output cau_pkg::out_t      res
);
	import cau_pkg::*;

	logic  en;
	logic  res_valid_q;
	out_t  res_q;

	// pipeline moves unless a finished item is held by the receiver
	assign en       = !(res_valid_q && res_stall);
	assign op_stall = !en;

	logic  chain_valid [DATA_WIDTH+1];
	work_t chain_work  [DATA_WIDTH+1];

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (op_valid),
		.op        (op),
		.out_valid (chain_valid[0]),
		.work      (chain_work[0])
	);

	// one divider and root step per stage, most significant bit first
	for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_iter
		cau_iter #(
			.STEP (k)
		) u_iter (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_valid[k]),
			.w_in      (chain_work[k]),
			.out_valid (chain_valid[k+1]),
			.w_out     (chain_work[k+1])
		);
	end

	// final sign, clipping and status
	work_t wl;
	sat_t  fr, fi;
	out_t  nxt;

	always_comb begin
		wl = chain_work[DATA_WIDTH];
		fr = '0;
		fi = '0;
		nxt = '0;
		case (wl.mode)
			MODE_DIV: begin
				fr = div_fix(wl.neg_r, wl.ovf_r, wl.q_r);
				fi = div_fix(wl.neg_i, wl.ovf_i, wl.q_i);
				if (wl.divz) begin
					nxt.res_real = '0;
					nxt.res_imag = '0;
					nxt.status   = ST_DIVZ;
				end else begin
					nxt.res_real = fr.value;
					nxt.res_imag = fi.value;
					nxt.status   = (fr.sat || fi.sat) ? ST_SAT : ST_OK;
				end
			end
			MODE_MOD: begin
				// root of a non-negative value only clips at the top
				nxt.res_real = (wl.sq_root > POS_MAX) ? POS_MAX : wl.sq_root;
				nxt.res_imag = '0;
				nxt.status   = (wl.sq_root > POS_MAX) ? ST_SAT : ST_OK;
			end
			default: begin
				nxt.res_real = wl.res_r;
				nxt.res_imag = wl.res_i;
				nxt.status   = wl.sat ? ST_SAT : ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= chain_valid[DATA_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// division by zero always returns zero components
	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_DIVZ |-> res.res_real == '0 && res.res_imag == '0)
		else $error("division by zero result not zero");

	// status code stays within the defined set
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.status == ST_OK || res.status == ST_SAT || res.status == ST_DIVZ))
		else $error("undefined status code");

	// a division whose real part did not overflow leaves a real remainder below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[DATA_WIDTH] && chain_work[DATA_WIDTH].mode == MODE_DIV
			&& !chain_work[DATA_WIDTH].divz && !chain_work[DATA_WIDTH].ovf_r
			|-> chain_work[DATA_WIDTH].rem_r < chain_work[DATA_WIDTH].den)
		else $error("divider remainder out of range");

	// the input side stalls only while a result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		op_stall |-> res_valid && res_stall)
		else $error("input stalled without held result");

endmodule

`default_nettype wire
